// ----- design/wma_pkg.sv -----
// Shared constants and types for the three-channel weighted moving average.
`timescale 1ns / 1ps
`default_nettype none

package wma_pkg;

    localparam int WINDOW       = 8;
    localparam int CHANNELS     = 3;
    localparam int NUM_FIELDS   = 3;
    localparam int SAMPLE_W     = 10;
    localparam int AVG_W        = 8;
    localparam int SAMPLE_SHIFT = SAMPLE_W - AVG_W;
    localparam int AVG_MAX      = (2 ** AVG_W) - 1;

    // Divisor for the weighted sum: 1 + 2 + ... + WINDOW.
    localparam int NORM      = WINDOW * (WINDOW + 1) / 2;
    localparam int TOTAL_W   = $clog2(AVG_MAX * WINDOW + 1);
    localparam int WSUM_W    = $clog2(AVG_MAX * NORM + 1);
    // Reciprocal of NORM scaled by 2^WSUM_W; truncation leaves q low by at most one.
    localparam int RECIP     = (2 ** WSUM_W) / NORM;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = WSUM_W + RECIP_W;
    localparam int FILL_W    = $clog2(WINDOW + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_left;
        logic [SAMPLE_W-1:0] sample_center;
        logic [SAMPLE_W-1:0] sample_right;
    } sample_in_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg_left;
        logic [AVG_W-1:0] avg_center;
        logic [AVG_W-1:0] avg_right;
    } avg_out_t;

    // Per-lane control from the pipeline controller.
    typedef struct packed {
        logic load;   // transfer accepted: shift in sample, update sums
        logic full;   // window full: oldest sample leaves the plain sum
        logic adv2;   // divide stage takes the current weighted sum
    } lane_ctrl_t;

endpackage : wma_pkg

`default_nettype wire

// ----- design/wma_lane.sv -----
// One channel lane: sample window, running sums and constant divider.
`timescale 1ns / 1ps
`default_nettype none

module wma_lane
    import wma_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_ctrl_t       ctrl,
    input  wire logic [AVG_W-1:0] x_new,
    output logic      [AVG_W-1:0] quot
);

    logic [AVG_W-1:0]   line_reg [WINDOW];
    logic [AVG_W-1:0]   x_old;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [WSUM_W-1:0]  wsum_next;
    logic [PROD_W-1:0]  prod;
    logic [AVG_W-1:0]   q0_next;
    logic [AVG_W-1:0]   q0_reg;
    logic [WSUM_W-1:0]  w2_reg;
    logic [WSUM_W-1:0]  rem;

    // Shift line; last tap is the sample that leaves the window.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            line_reg[0] <= x_new;
            for (int i = 1; i < WINDOW; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign x_old = ctrl.full ? line_reg[WINDOW-1] : '0;

    // Every held sample drops one weight unit; new one enters at WINDOW.
    assign total_next = total_reg - TOTAL_W'(x_old) + TOTAL_W'(x_new);
    assign wsum_next  = wsum_reg - WSUM_W'(total_reg)
                        + WSUM_W'(x_new) * WSUM_W'(WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            wsum_reg  <= '0;
        end
        else if (ctrl.load)
        begin
            total_reg <= total_next;
            wsum_reg  <= wsum_next;
        end
    end

    // Divide stage: reciprocal estimate, low by at most one.
    assign prod    = PROD_W'(wsum_reg) * PROD_W'(RECIP);
    assign q0_next = prod[WSUM_W +: AVG_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            q0_reg <= q0_next;
            w2_reg <= wsum_reg;
        end
    end

    // Correction: remainder below 2*NORM, one compare fixes the quotient.
    assign rem  = w2_reg - WSUM_W'(q0_reg) * WSUM_W'(NORM);
    assign quot = q0_reg + AVG_W'(rem >= WSUM_W'(NORM));

endmodule : wma_lane

`default_nettype wire

// ----- design/wma_merge.sv -----
// Output stage: gathers lane quotients into the result register.
`timescale 1ns / 1ps
`default_nettype none

module wma_merge
    import wma_pkg::*;
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             lane_valid,
    input  wire logic [CHANNELS-1:0][AVG_W-1:0]   quot,
    input  wire logic                             avg_stall,
    output logic                                  avg_valid,
    output avg_out_t                              avg,
    output logic                                  adv
);

    logic [NUM_FIELDS-1:0][AVG_W-1:0] field;
    avg_out_t                         avg_next;
    avg_out_t                         avg_reg;
    logic                             valid_reg;

    // Fields without a lane read zero.
    for (genvar c = 0; c < NUM_FIELDS; c++)
    begin : g_field
        if (c < CHANNELS)
        begin : g_live
            assign field[c] = quot[c];
        end
        else
        begin : g_none
            assign field[c] = '0;
        end
    end

    assign avg_next.avg_left   = field[0];
    assign avg_next.avg_center = field[1];
    assign avg_next.avg_right  = field[2];

    assign adv = !valid_reg || !avg_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= lane_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg_valid = valid_reg;
    assign avg       = avg_reg;

endmodule : wma_merge

`default_nettype wire

// ----- design/weighted_moving_average_3ch.sv -----
// Top level of the three-channel linearly weighted moving average.
//
// Input channel (sample_valid / sample_stall / sample): one transfer carries a
// 10-bit reading for the left, center and right sensor. The two low bits are
// dropped and the 8-bit value enters a WINDOW-deep window per channel.
// Output channel (avg_valid / avg_stall / avg): one 8-bit weighted average per
// channel, newest sample weighted WINDOW, oldest weighted 1, divided by
// WINDOW*(WINDOW+1)/2 and rounded down.
// The first WINDOW-1 transfers only fill the window and give no result; from
// the WINDOW-th on, every input transfer gives exactly one result.
// Pipeline: a result passes from its input transfer through the sum update,
// the reciprocal multiply and the correction into the output register.
// Throughput: one transfer per cycle while sample_stall is low; the lanes run
// side by side, one per channel.
// Reset empties the window, clears the sums and drops any result in flight.
// When avg_stall holds, the output register keeps its result; the pipeline
// stages behind it fill, and sample_stall rises only once every stage holds
// an item or a pending result.
`timescale 1ns / 1ps
`default_nettype none

module weighted_moving_average_3ch
    import wma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sample_valid,
    output logic            sample_stall,
    input  wire sample_in_t sample,
    output logic            avg_valid,
    input  wire logic       avg_stall,
    output avg_out_t        avg
);

    logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] raw;
    logic [CHANNELS-1:0][AVG_W-1:0]      quot;
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic                                v1_reg;
    logic                                v2_reg;
    logic                                adv1;
    logic                                adv2;
    logic                                adv3;
    logic                                accept;
    logic                                result_due;
    lane_ctrl_t                          lane_ctrl;

    assign raw[0] = sample.sample_left;
    assign raw[1] = sample.sample_center;
    assign raw[2] = sample.sample_right;

    // Stall chain: a stage moves when it is empty or the next one moves.
    assign adv2         = !v2_reg || adv3;
    assign adv1         = !v1_reg || adv2;
    assign sample_stall = !adv1;
    assign accept       = sample_valid && adv1;

    // Result due once this transfer completes the window.
    assign result_due = (fill_reg >= FILL_W'(WINDOW - 1));
    assign fill_next  = (accept && (fill_reg < FILL_W'(WINDOW))) ? fill_reg + 1'b1
                                                                 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (adv1)
            begin
                v1_reg <= accept && result_due;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage 1 data is each lane's weighted-sum register itself: it changes
    // only on a new transfer, which happens only as stage 1 moves on.
    assign lane_ctrl.load = accept;
    assign lane_ctrl.full = (fill_reg == FILL_W'(WINDOW));
    assign lane_ctrl.adv2 = adv2;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic [AVG_W-1:0] x_new;

        // Channels past the three sensor fields are fed zero.
        if (c < NUM_FIELDS)
        begin : g_fed
            assign x_new = raw[c][SAMPLE_W-1:SAMPLE_SHIFT];
        end
        else
        begin : g_idle
            assign x_new = '0;
        end

        wma_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .x_new (x_new),
            .quot  (quot[c])
        );
    end

    wma_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (v2_reg),
        .quot       (quot),
        .avg_stall  (avg_stall),
        .avg_valid  (avg_valid),
        .avg        (avg),
        .adv        (adv3)
    );

endmodule : weighted_moving_average_3ch

`default_nettype wire

// ----- design/wma_checker.sv -----
// Port-level checks for the weighted moving average, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wma_checker
    import wma_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       sample_valid,
    input wire logic       sample_stall,
    input wire logic       avg_valid,
    input wire logic       avg_stall,
    input wire avg_out_t   avg
);

    // A stalled result stays.
    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        avg_valid && avg_stall |=> avg_valid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        avg_valid && avg_stall |=> $stable(avg))
        else $error("result changed while stalled");

    // With no result waiting, the input side never stalls.
    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !avg_valid |-> !sample_stall)
        else $error("input stalled with empty output");

    // A fresh result comes from an earlier accepted input transfer.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(avg_valid) |-> $past(sample_valid && !sample_stall, 3))
        else $error("result without matching input transfer");

endmodule : wma_checker

bind weighted_moving_average_3ch wma_checker u_wma_checker (.*);

`default_nettype wire
